/* sv/coalescing_deadline_queue_assert.svh */
// Assertion macros for the coalescing deadline queue.
// Define ASSERT_OFF to compile the checks out.
`ifndef COALESCING_DEADLINE_QUEUE_ASSERT_SVH
`define COALESCING_DEADLINE_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cdq assertion failed");
// Next-cycle implication.
`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cdq assertion failed");
`else
`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/cdq_pkg.sv */
package cdq_pkg;

  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefKeyBits    = 16;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned RemW   = 7;
  localparam int unsigned SlackW = 16;

  localparam logic [SlackW-1:0] DefSlack = 16'd5000;
  localparam logic [RemW-1:0]   RemMax   = 7'd127;

  // operation codes
  localparam logic [ModeW-1:0] MODE_ADD      = 3'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE   = 3'd1;
  localparam logic [ModeW-1:0] MODE_POP      = 3'd2;
  localparam logic [ModeW-1:0] MODE_INFLIGHT = 3'd3;
  localparam logic [ModeW-1:0] MODE_PUSH     = 3'd4;

  // entry types
  localparam logic [TypeW-1:0] T_STATUS   = 3'd0;
  localparam logic [TypeW-1:0] T_TIMER    = 3'd1;
  localparam logic [TypeW-1:0] T_ONLINE   = 3'd2;
  localparam logic [TypeW-1:0] T_PERIODIC = 3'd3;
  localparam logic [TypeW-1:0] T_XSTATUS  = 3'd4;

  // result status
  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_SUPP = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;
  localparam logic [StatW-1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* sv/cdq_if.sv */
interface cdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::ModeW-1:0]     mode;
  logic [cdq_pkg::KeyW-1:0]      contact_key;
  logic [cdq_pkg::TimeW-1:0]     time_value;
  logic [cdq_pkg::TypeW-1:0]     entry_type;
  logic                          flag;

  modport source (output valid, mode, contact_key, time_value, entry_type, flag,
                  input ready);
  modport sink (input valid, mode, contact_key, time_value, entry_type, flag,
                output ready);
endinterface

interface cdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::StatW-1:0]     status;
  logic [cdq_pkg::KeyW-1:0]      out_contact;
  logic [cdq_pkg::TimeW-1:0]     out_time;
  logic [cdq_pkg::TypeW-1:0]     out_type;
  logic [cdq_pkg::RemW-1:0]      removed_count;

  modport source (output valid, status, out_contact, out_time, out_type, removed_count,
                  input ready);
  modport sink (input valid, status, out_contact, out_time, out_type, removed_count,
                output ready);
endinterface

/* sv/cdq_store.sv */
module cdq_store #(
  parameter int unsigned DEPTH = cdq_pkg::DefQueueDepth,
  parameter int unsigned EW    = 51
) (
  input  logic                     clk_i,
  input  cdq_pkg::mem_ctl_t        ctl_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [EW-1:0]            wr_data_i,
  output logic [EW-1:0]            rd_data_o
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* sv/coalescing_deadline_queue.sv */
// Coalescing deadline queue: timed poll requests kept in due-time order, earliest
// at the head, plus one in-flight contact key.
// Channels: req_i carries one operation per beat (add, remove key, pop due,
// set in-flight, push front); rsp_o returns exactly one result beat per request.
// cfg_we_i/cfg_wdata_i write the remove slack; write only while the block is idle.
// Entries live in a circular single-port-write, registered-read memory of
// QUEUE_DEPTH entries. Pop and push front move the head pointer.
// Work per request, request beat to result beat:
//   set in-flight, push front, empty pop, unknown mode: straight to the result
//   pop with entries: a registered read of the head entry, then the result
//   remove: a compaction pass over the stored entries; add: the same pass, then,
//   unless the new entry lands at the tail, an insert shift of the survivors
//   behind the insert point, then the write of the new entry; the compaction
//   pass reads one entry per cycle through the memory read port, and the insert
//   shift moves one entry per cycle.
// One request is worked at a time. A new request is taken once the previous one
// has been handed to the output register, even while that result still waits.
// If the receiver stalls, the finished result waits in the work registers and
// no further request is taken.
// Reset empties the queue, clears the in-flight key and sets the slack to 5000;
// no clearing pass is needed, stale memory words are never read.
`include "coalescing_deadline_queue_assert.svh"

module coalescing_deadline_queue #(
  parameter int unsigned QUEUE_DEPTH = cdq_pkg::DefQueueDepth,
  parameter int unsigned KEY_BITS    = cdq_pkg::DefKeyBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cdq_pkg::SlackW-1:0]   cfg_wdata_i,
  cdq_in_if.sink                       req_i,
  cdq_out_if.source                    rsp_o
);

  localparam int unsigned KW = (KEY_BITS < cdq_pkg::KeyW) ? KEY_BITS : cdq_pkg::KeyW;
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = cdq_pkg::TimeW;
  localparam int unsigned YW = cdq_pkg::TypeW;
  localparam int unsigned EW = KW + TW + YW;

  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DepthW = (CW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // control state
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          infl_v_q, infl_v_d;
  logic [KW-1:0] infl_key_q, infl_key_d;
  logic [cdq_pkg::SlackW-1:0] slack_q, slack_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] w_q, w_d;
  logic          dv_q, dv_d;
  logic          found_q, found_d;
  logic          block_q, block_d;
  logic          out_v_q, out_v_d;

  // request and work registers
  logic [cdq_pkg::ModeW-1:0] mode_q, mode_d;
  logic [KW-1:0]             key_q, key_d;
  logic [TW-1:0]             tm_q, tm_d;
  logic [YW-1:0]             ty_q, ty_d;
  logic                      flag_q, flag_d;
  logic [CW-1:0]             si_q, si_d;
  logic [CW-1:0]             pos_q, pos_d;
  logic [cdq_pkg::StatW-1:0] stat_q, stat_d;
  logic [cdq_pkg::RemW-1:0]  rem_q, rem_d;
  logic [KW-1:0]             po_key_q, po_key_d;
  logic [TW-1:0]             po_time_q, po_time_d;
  logic [YW-1:0]             po_type_q, po_type_d;

  // output register
  logic [cdq_pkg::StatW-1:0] out_stat_q, out_stat_d;
  logic [KW-1:0]             out_key_q, out_key_d;
  logic [TW-1:0]             out_time_q, out_time_d;
  logic [YW-1:0]             out_type_q, out_type_d;
  logic [cdq_pkg::RemW-1:0]  out_rem_q, out_rem_d;

  // memory port
  cdq_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [EW-1:0]     wr_data, rd_data;

  // entry under test
  logic [KW-1:0] e_key;
  logic [TW-1:0] e_time;
  logic [YW-1:0] e_type;
  logic          kill, blk;
  logic [KW-1:0] in_key;
  logic [YW-1:0] in_type;
  logic          add_block;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[AW-1:0];
  endfunction

  cdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .EW    (EW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign e_key  = rd_data[EW-1 -: KW];
  assign e_time = rd_data[YW +: TW];
  assign e_type = rd_data[YW-1:0];

  assign in_key  = req_i.contact_key[KW-1:0];
  // fold unknown types into periodic
  assign in_type = (req_i.entry_type > cdq_pkg::T_XSTATUS) ? cdq_pkg::T_PERIODIC
                                                           : req_i.entry_type;

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.status        = out_stat_q;
  assign rsp_o.out_contact   = cdq_pkg::KeyW'(out_key_q);
  assign rsp_o.out_time      = out_time_q;
  assign rsp_o.out_type      = out_type_q;
  assign rsp_o.removed_count = out_rem_q;

  // Coalescing rules: decide drop and suppress for one stored entry.
  always_comb begin
    kill = 1'b0;
    blk  = 1'b0;
    if (mode_q == cdq_pkg::MODE_REMOVE) begin
      kill = (e_type != cdq_pkg::T_TIMER) || (e_time <= tm_q);
    end else begin
      case (ty_q)
        cdq_pkg::T_XSTATUS, cdq_pkg::T_ONLINE: begin
          kill = 1'b1;
        end
        cdq_pkg::T_STATUS: begin
          if (e_type == cdq_pkg::T_ONLINE) begin
            blk = 1'b1;
          end else begin
            kill = 1'b1;
          end
        end
        cdq_pkg::T_TIMER: begin
          kill = e_type inside {cdq_pkg::T_TIMER, cdq_pkg::T_PERIODIC};
          blk  = (e_type == cdq_pkg::T_ONLINE);
        end
        default: begin
        end
      endcase
    end
    if (e_key != key_q) begin
      kill = 1'b0;
      blk  = 1'b0;
    end
  end

  // A status change add is also held off by a matching in-flight key.
  assign add_block = block_q || ((ty_q == cdq_pkg::T_STATUS) && infl_v_q &&
                                 (infl_key_q == key_q));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    infl_v_d   = infl_v_q;
    infl_key_d = infl_key_q;
    slack_d    = slack_q;
    rd_d       = rd_q;
    w_d        = w_q;
    dv_d       = dv_q;
    found_d    = found_q;
    block_d    = block_q;
    out_v_d    = out_v_q;
    mode_d     = mode_q;
    key_d      = key_q;
    tm_d       = tm_q;
    ty_d       = ty_q;
    flag_d     = flag_q;
    si_d       = si_q;
    pos_d      = pos_q;
    stat_d     = stat_q;
    rem_d      = rem_q;
    po_key_d   = po_key_q;
    po_time_d  = po_time_q;
    po_type_d  = po_type_q;
    out_stat_d = out_stat_q;
    out_key_d  = out_key_q;
    out_time_d = out_time_q;
    out_type_d = out_type_q;
    out_rem_d  = out_rem_q;
    mem_ctl    = '0;
    rd_addr    = head_q;
    wr_addr    = head_q;
    wr_data    = rd_data;

    if (cfg_we_i) begin
      slack_d = cfg_wdata_i;
    end

    // drop the output beat once taken
    if (out_v_q && rsp_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d    = req_i.mode;
          key_d     = in_key;
          tm_d      = req_i.time_value;
          ty_d      = in_type;
          flag_d    = req_i.flag;
          stat_d    = cdq_pkg::ST_OK;
          rem_d     = '0;
          po_key_d  = '0;
          po_time_d = '0;
          po_type_d = '0;
          rd_d      = '0;
          w_d       = '0;
          dv_d      = 1'b0;
          found_d   = 1'b0;
          block_d   = 1'b0;
          state_d   = S_DONE;
          case (req_i.mode)
            cdq_pkg::MODE_ADD: begin
              state_d = S_SWEEP;
            end
            cdq_pkg::MODE_REMOVE: begin
              // compare against now + slack, wrapping
              tm_d    = req_i.time_value + TW'(slack_q);
              state_d = S_SWEEP;
            end
            cdq_pkg::MODE_POP: begin
              if (count_q == '0) begin
                stat_d = cdq_pkg::ST_NONE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = head_q;
                state_d       = S_POP;
              end
            end
            cdq_pkg::MODE_INFLIGHT: begin
              infl_v_d   = req_i.flag;
              infl_key_d = req_i.flag ? in_key : '0;
            end
            cdq_pkg::MODE_PUSH: begin
              if (count_q >= DepthC) begin
                stat_d = cdq_pkg::ST_FULL;
              end else begin
                head_d        = (head_q == '0) ? LastA : head_q - 1'b1;
                mem_ctl.wr_en = 1'b1;
                wr_addr       = head_d;
                wr_data       = {in_key, req_i.time_value, in_type};
                count_d       = count_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SWEEP: begin
        // read ahead one entry per cycle; survivors are written back compacted
        if (rd_q < count_q) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = phys(head_q, rd_q);
          rd_d          = rd_q + 1'b1;
          dv_d          = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          if (blk) begin
            block_d = 1'b1;
          end
          if (kill) begin
            if (rem_q != cdq_pkg::RemMax) begin
              rem_d = rem_q + 1'b1;
            end
          end else begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = phys(head_q, w_q);
            wr_data       = rd_data;
            w_d           = w_q + 1'b1;
            // first survivor due later marks the insert point
            if ((mode_q == cdq_pkg::MODE_ADD) && !found_q && (e_time > tm_q)) begin
              found_d = 1'b1;
              pos_d   = w_q;
            end
          end
        end
        if ((rd_q == count_q) && !dv_q) begin
          count_d = w_q;
          if (mode_q == cdq_pkg::MODE_REMOVE) begin
            if (flag_q && infl_v_q && (infl_key_q == key_q)) begin
              infl_v_d   = 1'b0;
              infl_key_d = '0;
            end
            state_d = S_DONE;
          end else if (add_block) begin
            stat_d  = cdq_pkg::ST_SUPP;
            state_d = S_DONE;
          end else if (w_q >= DepthC) begin
            stat_d  = cdq_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            if (!found_q) begin
              pos_d = w_q;
            end
            rd_d    = w_q;
            dv_d    = 1'b0;
            state_d = found_q ? S_SHIFT : S_PUT;
          end
        end
      end

      S_SHIFT: begin
        // move the tail up by one, last entry first
        if (rd_q > pos_q) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = phys(head_q, rd_q - 1'b1);
          rd_d          = rd_q - 1'b1;
          si_d          = rd_q - 1'b1;
          dv_d          = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = phys(head_q, si_q + 1'b1);
          wr_data       = rd_data;
        end
        if ((rd_q == pos_q) && !dv_q) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = phys(head_q, pos_q);
        wr_data       = {key_q, tm_q, ty_q};
        count_d       = count_q + 1'b1;
        state_d       = S_DONE;
      end

      S_POP: begin
        if (e_time <= tm_q) begin
          po_key_d  = e_key;
          po_time_d = e_time;
          po_type_d = e_type;
          head_d    = (head_q == LastA) ? '0 : head_q + 1'b1;
          count_d   = count_q - 1'b1;
        end else begin
          stat_d = cdq_pkg::ST_NONE;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_v_q || rsp_o.ready) begin
          out_v_d    = 1'b1;
          out_stat_d = stat_q;
          out_key_d  = po_key_q;
          out_time_d = po_time_q;
          out_type_d = po_type_q;
          out_rem_d  = rem_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      infl_v_q   <= 1'b0;
      infl_key_q <= '0;
      slack_q    <= cdq_pkg::DefSlack;
      rd_q       <= '0;
      w_q        <= '0;
      dv_q       <= 1'b0;
      found_q    <= 1'b0;
      block_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      infl_v_q   <= infl_v_d;
      infl_key_q <= infl_key_d;
      slack_q    <= slack_d;
      rd_q       <= rd_d;
      w_q        <= w_d;
      dv_q       <= dv_d;
      found_q    <= found_d;
      block_q    <= block_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    tm_q       <= tm_d;
    ty_q       <= ty_d;
    flag_q     <= flag_d;
    si_q       <= si_d;
    pos_q      <= pos_d;
    stat_q     <= stat_d;
    rem_q      <= rem_d;
    po_key_q   <= po_key_d;
    po_time_q  <= po_time_d;
    po_type_q  <= po_type_d;
    out_stat_q <= out_stat_d;
    out_key_q  <= out_key_d;
    out_time_q <= out_time_d;
    out_type_q <= out_type_d;
    out_rem_q  <= out_rem_d;
  end

  `CDQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= DepthC)
  `CDQ_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_i.ready, state_q != S_IDLE)
  `CDQ_ASSERT_IMP(a_compact_behind_read, clk_i, rst_ni, state_q == S_SWEEP, w_q <= rd_q)
  `CDQ_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, mem_ctl.rd_en && mem_ctl.wr_en, rd_addr != wr_addr)

endmodule
